[hw/rtl/ata_tf_pkg.sv]
package ata_tf_pkg;

    // Codes carried in tuser on the request channel.
    localparam logic [2:0] IN_REG_RD = 3'd0;
    localparam logic [2:0] IN_REG_WR = 3'd1;
    localparam logic [2:0] IN_FILL   = 3'd2;
    localparam logic [2:0] IN_FETCH  = 3'd3;
    localparam logic [2:0] IN_DONE   = 3'd4;

    // Taskfile register indexes.
    localparam logic [3:0] RI_ALT     = 4'd0;
    localparam logic [3:0] RI_DATA    = 4'd1;
    localparam logic [3:0] RI_ERR     = 4'd2;
    localparam logic [3:0] RI_COUNT   = 4'd3;
    localparam logic [3:0] RI_LBA_LO  = 4'd4;
    localparam logic [3:0] RI_LBA_MID = 4'd5;
    localparam logic [3:0] RI_LBA_HI  = 4'd6;
    localparam logic [3:0] RI_DEV     = 4'd7;
    localparam logic [3:0] RI_STATUS  = 4'd8;

    // ATA command opcodes.
    localparam logic [7:0] CMD_IDENTIFY  = 8'hEC;
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
    localparam logic [7:0] CMD_DMA_RD    = 8'hC8;
    localparam logic [7:0] CMD_DMA_WR    = 8'hCA;
    localparam logic [7:0] CMD_DMA_RD_X  = 8'h25;
    localparam logic [7:0] CMD_DMA_WR_X  = 8'h35;
    localparam logic [7:0] CMD_FLUSH     = 8'hE7;
    localparam logic [7:0] CMD_FLUSH_EXT = 8'hEA;
    localparam logic [7:0] CMD_SET_FEAT  = 8'hEF;

    // Status and error values.
    localparam logic [7:0] ST_IDLE   = 8'h50;
    localparam logic [7:0] ST_DRQ    = 8'h58;
    localparam logic [7:0] ST_BUSY   = 8'hD0;
    localparam logic [7:0] ST_ABORT  = 8'h41;
    localparam logic [7:0] ERR_ABORT = 8'h04;
    localparam logic [7:0] ERR_DIAG  = 8'h01;
    localparam logic [7:0] DEV_RESET = 8'hA0;
    localparam int         SRST_BIT  = 2;

    // Outstanding media operation.
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_READ  = 2'd1;
    localparam logic [1:0] PEND_WRITE = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_REG_RD,
        OP_REG_WR,
        OP_DATA_RD,
        OP_DATA_WR,
        OP_FILL,
        OP_FETCH,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  reg_index;
        logic [2:0]  nbytes;
        logic [31:0] wdata;
        logic [6:0]  word_index;
        logic        media_ok;
    } req_t;

    // Byte lanes covered by an access of n bytes, n at most four.
    function automatic logic [3:0] nb_mask(input logic [2:0] n);
        logic [3:0] m;
        unique case (n)
            3'd0:    m = 4'b0000;
            3'd1:    m = 4'b0001;
            3'd2:    m = 4'b0011;
            3'd3:    m = 4'b0111;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

    // One 16-bit word of the identify page; text is stored high character first.
    function automatic logic [15:0] ident_half(input logic [6:0] i, input logic [47:0] cap);
        logic [27:0] c28;
        logic [15:0] h;
        c28 = (cap < 48'h0FFF_FFFF) ? cap[27:0] : 28'hFFF_FFFF;
        case (i)
            7'd0:   h = 16'h0040;
            7'd1:   h = 16'h3FFF;
            7'd3:   h = 16'h0010;
            7'd6:   h = 16'h003F;
            7'd10:  h = 16'h5245;
            7'd11:  h = 16'h4644;
            7'd12:  h = 16'h4953;
            7'd13:  h = 16'h4B2D;
            7'd14:  h = 16'h3030;
            7'd15:  h = 16'h3031;
            7'd16, 7'd17, 7'd18, 7'd19: h = 16'h2020;
            7'd23:  h = 16'h312E;
            7'd24:  h = 16'h3030;
            7'd25, 7'd26: h = 16'h2020;
            7'd27:  h = 16'h4154;
            7'd28:  h = 16'h4120;
            7'd29:  h = 16'h5245;
            7'd30:  h = 16'h4645;
            7'd31:  h = 16'h5245;
            7'd32:  h = 16'h4E43;
            7'd33:  h = 16'h4520;
            7'd34:  h = 16'h4449;
            7'd35:  h = 16'h534B;
            7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41,
            7'd42, 7'd43, 7'd44, 7'd45, 7'd46: h = 16'h2020;
            7'd47:  h = 16'h8001;
            7'd49:  h = 16'h0200;
            7'd50:  h = 16'h4000;
            7'd53:  h = 16'h0007;
            7'd59:  h = 16'h0101;
            7'd60:  h = c28[15:0];
            7'd61:  h = {4'h0, c28[27:16]};
            7'd63:  h = 16'h0007;
            7'd64:  h = 16'h0003;
            7'd80:  h = 16'h007E;
            7'd82:  h = 16'h0020;
            7'd83:  h = 16'h4400;
            7'd84:  h = 16'h4000;
            7'd86:  h = 16'h0400;
            7'd87:  h = 16'h4000;
            7'd88:  h = 16'h0007;
            7'd100: h = cap[15:0];
            7'd101: h = cap[31:16];
            7'd102: h = cap[47:32];
            default: h = 16'h0000;
        endcase
        return h;
    endfunction

    // One 32-bit buffer word of the identify page, for buffer words below 64.
    function automatic logic [31:0] ident_word(input logic [5:0] k, input logic [47:0] cap);
        return {ident_half({k, 1'b1}, cap), ident_half({k, 1'b0}, cap)};
    endfunction

endpackage

[hw/rtl/ata_tf_front.sv]
module ata_tf_front
    import ata_tf_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output logic        req_valid,
    input  logic        req_ready,
    output req_t        req
);

    logic [3:0] ridx;
    logic [2:0] size;

    assign ridx = s_tdata[3:0];
    assign size = s_tdata[6:4];

    always_comb begin
        req.reg_index  = ridx;
        req.nbytes     = (size > 3'd4) ? 3'd4 : size;
        req.wdata      = s_tdata[38:7];
        req.word_index = s_tdata[45:39];
        req.media_ok   = s_tdata[46];
        unique case (s_tuser)
            IN_REG_RD: req.op = (ridx == RI_DATA) ? OP_DATA_RD : OP_REG_RD;
            IN_REG_WR: req.op = (ridx == RI_DATA) ? OP_DATA_WR : OP_REG_WR;
            IN_FILL:   req.op = OP_FILL;
            IN_FETCH:  req.op = OP_FETCH;
            IN_DONE:   req.op = OP_DONE;
            default:   req.op = OP_NOP;
        endcase
    end

    assign req_valid = s_tvalid;
    assign s_tready  = req_ready;

endmodule

[hw/rtl/ata_tf_queue.sv]
module ata_tf_queue
    import ata_tf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output req_t out_data
);

    req_t       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= in_data;
        end
    end

endmodule

[hw/rtl/ata_tf_buf.sv]
module ata_tf_buf #(
    parameter int ROWS = 64,
    parameter int RW   = 6
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [RW-1:0] row_even,
    input  logic [RW-1:0] row_odd,
    input  logic [3:0]    we_even,
    input  logic [3:0]    we_odd,
    input  logic [31:0]   wd_even,
    input  logic [31:0]   wd_odd,
    output logic [31:0]   rq_even,
    output logic [31:0]   rq_odd
);

    // Even and odd 32-bit words sit in separate banks so that an access
    // straddling a word boundary touches each bank once.
    logic [31:0] even_mem [ROWS];
    logic [31:0] odd_mem  [ROWS];

    always_ff @(posedge aclk) begin
        for (int b = 0; b < 4; b++) begin
            if (we_even[b]) begin
                even_mem[row_even][8*b +: 8] <= wd_even[8*b +: 8];
            end
            if (we_odd[b]) begin
                odd_mem[row_odd][8*b +: 8] <= wd_odd[8*b +: 8];
            end
        end
        if (rd_en) begin
            rq_even <= even_mem[row_even];
            rq_odd  <= odd_mem[row_odd];
        end
    end

endmodule

[hw/rtl/ata_tf_exec.sv]
module ata_tf_exec
    import ata_tf_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [47:0]               cfg_wdata,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  req_t                      q_data,
    output logic                      buf_rd_en,
    output logic [$clog2(SECTOR_BYTES/8)-1:0] buf_row_even,
    output logic [$clog2(SECTOR_BYTES/8)-1:0] buf_row_odd,
    output logic [3:0]                buf_we_even,
    output logic [3:0]                buf_we_odd,
    output logic [31:0]               buf_wd_even,
    output logic [31:0]               buf_wd_odd,
    input  logic [31:0]               buf_rq_even,
    input  logic [31:0]               buf_rq_odd,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [87:0]               m_tdata
);

    localparam int WORDS = SECTOR_BYTES / 4;
    localparam int RW    = $clog2(SECTOR_BYTES / 8);
    localparam int WW    = RW + 1;
    localparam int PW    = $clog2(SECTOR_BYTES + 1);

    // Configuration.
    logic [47:0] sc_reg;
    logic        wp_reg;

    // Taskfile and transfer state.
    logic [15:0]      cp_reg, cp_next;
    logic [47:0]      lba_reg, lba_next;
    logic [7:0]       dev_reg, dev_next;
    logic [7:0]       st_reg, st_next;
    logic [7:0]       err_reg, err_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic             bv_reg, bv_next;
    logic             bw_reg, bw_next;
    logic [47:0]      cur_reg, cur_next;
    logic [16:0]      rem_reg, rem_next;
    logic             intr_reg, intr_next;
    logic [1:0]       pend_reg, pend_next;
    logic [47:0]      cap_reg, cap_next;
    // A set bit means the buffer RAM holds the word; a clear bit means the
    // word still shows the identify page.
    logic [WORDS-1:0] ovr_reg, ovr_next;

    // Result stage.
    logic        res_valid_reg;
    logic [31:0] res_rdata_reg, res_rdata_next;
    logic        res_mem_reg, res_mem_next;
    logic [1:0]  res_off_reg, res_off_next;
    logic [2:0]  res_n_reg, res_n_next;
    logic        res_sel_reg;
    logic        res_olo_reg, res_ohi_reg;
    logic [31:0] res_idlo_reg, res_idhi_reg;
    logic        res_intr_reg;
    logic [1:0]  res_req_reg, res_req_next;
    logic [47:0] res_lba_reg, res_lba_next;

    logic          fire;
    logic          word_op;
    logic [WW-1:0] ww, w1;
    logic [1:0]    off;
    logic [PW-1:0] avail;
    logic [2:0]    n;
    logic [31:0]   id_lo, id_hi;
    logic [7:0]    be8;
    logic [63:0]   d64;
    logic [3:0]    be_lo, be_hi, we_lo, we_hi;
    logic [31:0]   wd_lo, wd_hi;
    logic [47:0]   lba_cmd;
    logic [16:0]   cnt_cmd;
    logic          ext;
    logic          do_abort, do_rd_issue, do_wr_issue;
    logic [7:0]    cbyte;

    assign fire    = q_valid && (!res_valid_reg || m_tready);
    assign q_ready = fire;

    assign word_op = (q_data.op == OP_FILL) || (q_data.op == OP_FETCH);
    assign ww      = word_op ? WW'(q_data.word_index) : pos_reg[2 +: WW];
    assign w1      = ww + 1'b1;
    assign off     = word_op ? 2'd0 : pos_reg[1:0];
    assign avail   = PW'(SECTOR_BYTES) - pos_reg;
    assign n       = (PW'(q_data.nbytes) > avail) ? avail[2:0] : q_data.nbytes;
    assign id_lo   = ((ww >> 6) == '0) ? ident_word(ww[5:0], cap_reg) : 32'h0;
    assign id_hi   = ((w1 >> 6) == '0) ? ident_word(w1[5:0], cap_reg) : 32'h0;
    assign be8     = 8'({4'h0, nb_mask(n)} << off);
    assign d64     = 64'(q_data.wdata) << {off, 3'b000};
    assign be_lo   = be8[3:0];
    assign be_hi   = be8[7:4];
    assign cbyte   = q_data.wdata[7:0];
    assign ext     = (cbyte == CMD_READ_EXT) || (cbyte == CMD_WRITE_EXT) ||
                     (cbyte == CMD_DMA_RD_X) || (cbyte == CMD_DMA_WR_X);
    assign lba_cmd = ext ? lba_reg : {20'h0, dev_reg[3:0], lba_reg[23:0]};
    assign cnt_cmd = ext ? ((cp_reg == 16'h0) ? 17'h10000 : {1'b0, cp_reg})
                         : ((cp_reg[7:0] == 8'h0) ? 17'h00100 : {9'h0, cp_reg[7:0]});

    // A partial write into a word that still shows the identify page fills
    // the untouched bytes from the page so the whole word becomes real.
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            wd_lo[8*b +: 8] = be_lo[b] ? d64[8*b +: 8] : id_lo[8*b +: 8];
            wd_hi[8*b +: 8] = be_hi[b] ? d64[32 + 8*b +: 8] : id_hi[8*b +: 8];
        end
        we_lo = (ovr_reg[ww] || be_lo == 4'h0) ? be_lo : 4'hF;
        we_hi = (ovr_reg[w1] || be_hi == 4'h0) ? be_hi : 4'hF;
    end

    assign buf_row_odd  = ww[WW-1:1];
    assign buf_row_even = ww[0] ? w1[WW-1:1] : ww[WW-1:1];

    always_comb begin
        cp_next   = cp_reg;
        lba_next  = lba_reg;
        dev_next  = dev_reg;
        st_next   = st_reg;
        err_next  = err_reg;
        pos_next  = pos_reg;
        bv_next   = bv_reg;
        bw_next   = bw_reg;
        cur_next  = cur_reg;
        rem_next  = rem_reg;
        intr_next = intr_reg;
        pend_next = pend_reg;
        cap_next  = cap_reg;
        ovr_next  = ovr_reg;
        res_rdata_next = 32'h0;
        res_mem_next   = 1'b0;
        res_off_next   = off;
        res_n_next     = 3'd0;
        res_req_next   = PEND_NONE;
        res_lba_next   = 48'h0;
        buf_rd_en   = 1'b0;
        buf_we_even = 4'h0;
        buf_we_odd  = 4'h0;
        buf_wd_even = ww[0] ? wd_hi : wd_lo;
        buf_wd_odd  = ww[0] ? wd_lo : wd_hi;
        do_abort    = 1'b0;
        do_rd_issue = 1'b0;
        do_wr_issue = 1'b0;

        if (fire) begin
            unique case (q_data.op)
                OP_NOP: begin
                end
                OP_REG_RD: begin
                    unique case (q_data.reg_index)
                        RI_ALT:     res_rdata_next = {24'h0, st_reg};
                        RI_ERR:     res_rdata_next = {24'h0, err_reg};
                        RI_COUNT:   res_rdata_next = {24'h0, cp_reg[7:0]};
                        RI_LBA_LO:  res_rdata_next = {24'h0, lba_reg[7:0]};
                        RI_LBA_MID: res_rdata_next = {24'h0, lba_reg[15:8]};
                        RI_LBA_HI:  res_rdata_next = {24'h0, lba_reg[23:16]};
                        RI_DEV:     res_rdata_next = {24'h0, dev_reg};
                        RI_STATUS: begin
                            res_rdata_next = {24'h0, st_reg};
                            intr_next      = 1'b0;
                        end
                        default:    res_rdata_next = 32'h0;
                    endcase
                end
                OP_DATA_RD: begin
                    if (bv_reg && !bw_reg) begin
                        res_mem_next = 1'b1;
                        res_n_next   = n;
                        buf_rd_en    = 1'b1;
                        pos_next     = pos_reg + PW'(n);
                        do_rd_issue  = (pos_next >= PW'(SECTOR_BYTES));
                    end
                end
                OP_DATA_WR: begin
                    if (bv_reg && bw_reg) begin
                        buf_we_even = ww[0] ? we_hi : we_lo;
                        buf_we_odd  = ww[0] ? we_lo : we_hi;
                        if (be_lo != 4'h0) begin
                            ovr_next[ww] = 1'b1;
                        end
                        if (be_hi != 4'h0) begin
                            ovr_next[w1] = 1'b1;
                        end
                        pos_next    = pos_reg + PW'(n);
                        do_wr_issue = (pos_next >= PW'(SECTOR_BYTES));
                    end
                end
                OP_REG_WR: begin
                    unique case (q_data.reg_index)
                        RI_ALT: begin
                            if (q_data.wdata[SRST_BIT]) begin
                                st_next   = ST_IDLE;
                                err_next  = ERR_DIAG;
                                bv_next   = 1'b0;
                                rem_next  = 17'h0;
                                pend_next = PEND_NONE;
                            end
                        end
                        RI_COUNT:   cp_next = {cp_reg[7:0], cbyte};
                        RI_LBA_LO:  lba_next = {lba_reg[47:32], lba_reg[7:0],
                                                lba_reg[23:8], cbyte};
                        RI_LBA_MID: lba_next = {lba_reg[47:40], lba_reg[15:8],
                                                lba_reg[31:24], lba_reg[23:16],
                                                cbyte, lba_reg[7:0]};
                        RI_LBA_HI:  lba_next = {lba_reg[23:16], lba_reg[39:24],
                                                cbyte, lba_reg[15:0]};
                        RI_DEV:     dev_next = cbyte;
                        RI_STATUS: begin
                            if (pend_reg == PEND_NONE) begin
                                err_next = 8'h00;
                                priority case (cbyte)
                                    CMD_IDENTIFY: begin
                                        ovr_next  = '0;
                                        cap_next  = sc_reg;
                                        pos_next  = '0;
                                        bv_next   = 1'b1;
                                        bw_next   = 1'b0;
                                        rem_next  = 17'h0;
                                        st_next   = ST_DRQ;
                                        intr_next = 1'b1;
                                    end
                                    CMD_READ, CMD_READ_EXT: begin
                                        cur_next    = lba_cmd;
                                        rem_next    = cnt_cmd;
                                        do_rd_issue = 1'b1;
                                    end
                                    CMD_WRITE, CMD_WRITE_EXT: begin
                                        cur_next = lba_cmd;
                                        rem_next = cnt_cmd;
                                        pos_next = '0;
                                        bv_next  = 1'b1;
                                        bw_next  = 1'b1;
                                        st_next  = ST_DRQ;
                                    end
                                    CMD_DMA_RD, CMD_DMA_WR, CMD_DMA_RD_X, CMD_DMA_WR_X: begin
                                        cur_next = lba_cmd;
                                        rem_next = cnt_cmd;
                                        st_next  = ST_IDLE;
                                        bv_next  = 1'b0;
                                    end
                                    CMD_FLUSH, CMD_FLUSH_EXT, CMD_SET_FEAT: begin
                                        st_next   = ST_IDLE;
                                        intr_next = 1'b1;
                                    end
                                    default: do_abort = 1'b1;
                                endcase
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_FILL: begin
                    if (pend_reg == PEND_READ && 32'(q_data.word_index) < WORDS) begin
                        buf_wd_even  = q_data.wdata;
                        buf_wd_odd   = q_data.wdata;
                        buf_we_even  = ww[0] ? 4'h0 : 4'hF;
                        buf_we_odd   = ww[0] ? 4'hF : 4'h0;
                        ovr_next[ww] = 1'b1;
                    end
                end
                OP_FETCH: begin
                    if (32'(q_data.word_index) < WORDS) begin
                        res_mem_next = 1'b1;
                        res_n_next   = 3'd4;
                        buf_rd_en    = 1'b1;
                    end
                end
                OP_DONE: begin
                    if (pend_reg != PEND_NONE) begin
                        pend_next = PEND_NONE;
                        if (!q_data.media_ok) begin
                            do_abort = 1'b1;
                        end else begin
                            cur_next  = cur_reg + 48'h1;
                            rem_next  = rem_reg - 17'h1;
                            pos_next  = '0;
                            intr_next = 1'b1;
                            if (pend_reg == PEND_READ) begin
                                bv_next = 1'b1;
                                bw_next = 1'b0;
                                st_next = ST_DRQ;
                            end else if (rem_next == 17'h0) begin
                                bv_next = 1'b0;
                                bw_next = 1'b0;
                                st_next = ST_IDLE;
                            end else begin
                                bv_next = 1'b1;
                                bw_next = 1'b1;
                                st_next = ST_DRQ;
                            end
                        end
                    end
                end
            endcase
        end

        // Start the next sector of a PIO read, finish the command, or abort past the last sector.
        if (do_rd_issue) begin
            if (rem_next == 17'h0) begin
                st_next = ST_IDLE;
                bv_next = 1'b0;
            end else if (cur_next >= sc_reg) begin
                do_abort = 1'b1;
            end else begin
                pend_next    = PEND_READ;
                st_next      = ST_BUSY;
                bv_next      = 1'b0;
                bw_next      = 1'b0;
                res_req_next = PEND_READ;
                res_lba_next = cur_next;
            end
        end

        // A full buffer from the host goes out to the media, or aborts if write protected or past the last sector.
        if (do_wr_issue) begin
            if (wp_reg || cur_reg >= sc_reg) begin
                do_abort = 1'b1;
            end else begin
                pend_next    = PEND_WRITE;
                st_next      = ST_BUSY;
                bv_next      = 1'b0;
                bw_next      = 1'b1;
                res_req_next = PEND_WRITE;
                res_lba_next = cur_reg;
            end
        end

        if (do_abort) begin
            st_next      = ST_ABORT;
            err_next     = ERR_ABORT;
            bv_next      = 1'b0;
            pend_next    = PEND_NONE;
            intr_next    = 1'b1;
            res_req_next = PEND_NONE;
            res_lba_next = 48'h0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg        <= 48'h0;
            wp_reg        <= 1'b0;
            cp_reg        <= 16'h0;
            lba_reg       <= 48'h0;
            dev_reg       <= DEV_RESET;
            st_reg        <= ST_IDLE;
            err_reg       <= 8'h00;
            pos_reg       <= '0;
            bv_reg        <= 1'b0;
            bw_reg        <= 1'b0;
            cur_reg       <= 48'h0;
            rem_reg       <= 17'h0;
            intr_reg      <= 1'b0;
            pend_reg      <= PEND_NONE;
            ovr_reg       <= '1;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index) begin
                    wp_reg <= cfg_wdata[0];
                end else begin
                    sc_reg <= cfg_wdata;
                end
            end
            cp_reg   <= cp_next;
            lba_reg  <= lba_next;
            dev_reg  <= dev_next;
            st_reg   <= st_next;
            err_reg  <= err_next;
            pos_reg  <= pos_next;
            bv_reg   <= bv_next;
            bw_reg   <= bw_next;
            cur_reg  <= cur_next;
            rem_reg  <= rem_next;
            intr_reg <= intr_next;
            pend_reg <= pend_next;
            ovr_reg  <= ovr_next;
            if (fire) begin
                res_valid_reg <= 1'b1;
            end else if (m_tready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cap_reg <= cap_next;
        if (fire) begin
            res_rdata_reg <= res_rdata_next;
            res_mem_reg   <= res_mem_next;
            res_off_reg   <= res_off_next;
            res_n_reg     <= res_n_next;
            res_sel_reg   <= ww[0];
            res_olo_reg   <= ovr_reg[ww];
            res_ohi_reg   <= ovr_reg[w1];
            res_idlo_reg  <= id_lo;
            res_idhi_reg  <= id_hi;
            res_intr_reg  <= intr_next;
            res_req_reg   <= res_req_next;
            res_lba_reg   <= res_lba_next;
        end
    end

    logic [31:0] lo_q, hi_q, lo_w, hi_w, lane_mask, rdata;
    logic [63:0] cat;
    logic [3:0]  rm4;

    always_comb begin
        lo_q = res_sel_reg ? buf_rq_odd : buf_rq_even;
        hi_q = res_sel_reg ? buf_rq_even : buf_rq_odd;
        lo_w = res_olo_reg ? lo_q : res_idlo_reg;
        hi_w = res_ohi_reg ? hi_q : res_idhi_reg;
        cat  = {hi_w, lo_w} >> {res_off_reg, 3'b000};
        rm4  = nb_mask(res_n_reg);
        for (int b = 0; b < 4; b++) begin
            lane_mask[8*b +: 8] = {8{rm4[b]}};
        end
        rdata = res_mem_reg ? (cat[31:0] & lane_mask) : res_rdata_reg;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {5'h0, res_lba_reg, res_req_reg, res_intr_reg, rdata};

    a_busy_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != PEND_NONE |-> st_reg == ST_BUSY)
        else $error("media pending without BSY status");

    a_no_pio_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != PEND_NONE |-> !bv_reg)
        else $error("PIO buffer open while media pending");

    a_pos_in_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PW'(SECTOR_BYTES))
        else $error("buffer position beyond sector");

    a_request_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_req_next != PEND_NONE |=> pend_reg == res_req_reg)
        else $error("media request issued without matching pending state");

endmodule

[hw/rtl/ata_taskfile_pio_disk_unit.sv]
// ATA disk taskfile with LBA28/LBA48 addressing and a one-sector PIO buffer.
// Each request on the s_ channel (register read or write, or a media word
// fill, word fetch or done event) yields exactly one result on the m_
// channel carrying read data, the INTRQ level and any new media request.
// Requests are decoded and queued in a two-entry queue ahead of the
// executing stage, and a full rate of one request per clock is sustained
// with m_tready high; a request moves from its queue slot into the result
// registers of the execute stage, beside the registered read of the banked
// sector buffer. The user must write sector_count (index 0) and
// write_protect (index 1) on the cfg port only while the block is idle, which is not enforced.
module ata_taskfile_pio_disk_unit
    import ata_tf_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // reg_index[3:0], access_size[6:4], wdata[38:7], word_index[45:39], media_ok[46]
    input  logic [47:0] s_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // rdata[31:0], intrq[32], media_request[34:33], media_lba[82:35]
    output logic [87:0] m_tdata
);

    localparam int RW = $clog2(SECTOR_BYTES / 8);

    req_t        f_req, q_req;
    logic        f_valid, f_ready, q_valid, q_ready;
    logic        rd_en;
    logic [RW-1:0] row_even, row_odd;
    logic [3:0]  we_even, we_odd;
    logic [31:0] wd_even, wd_odd, rq_even, rq_odd;

    ata_tf_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (f_valid),
        .req_ready (f_ready),
        .req       (f_req)
    );

    ata_tf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_req),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_req)
    );

    ata_tf_buf #(
        .ROWS (SECTOR_BYTES / 8),
        .RW   (RW)
    ) u_buf (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .row_even (row_even),
        .row_odd  (row_odd),
        .we_even  (we_even),
        .we_odd   (we_odd),
        .wd_even  (wd_even),
        .wd_odd   (wd_odd),
        .rq_even  (rq_even),
        .rq_odd   (rq_odd)
    );

    ata_tf_exec #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_exec (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_req),
        .buf_rd_en    (rd_en),
        .buf_row_even (row_even),
        .buf_row_odd  (row_odd),
        .buf_we_even  (we_even),
        .buf_we_odd   (we_odd),
        .buf_wd_even  (wd_even),
        .buf_wd_odd   (wd_odd),
        .buf_rq_even  (rq_even),
        .buf_rq_odd   (rq_odd),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
